>>> src/wis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_pkg
// Shared types and constants of the weighted index sampler.
// ----------------------------------------------------------------------------
package wis_pkg;

    // Request codes (code 3 is unused and ignored)
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_DRAW   = 2'd2;

    // Width of the running total and of each cumulative table entry
    localparam int unsigned TOTAL_BITS = 40;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // Width of the input weight port
    localparam int unsigned WEIGHT_PORT_BITS = 32;

    // Generator constants
    localparam logic [63:0] GOLDEN_SEED   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] SCRAMBLE_MULT = 64'd2685821657736338717;

    // Fraction keeps the top 53 bits of the scrambled word
    localparam int unsigned FRAC_BITS = 53;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RNG,
        ST_MUL1,
        ST_MUL2,
        ST_RD,
        ST_CMP,
        ST_EMIT
    } state_t;

    // Generator controls
    typedef struct packed {
        logic load;
        logic step;
    } rng_ctl_t;

endpackage

>>> src/wis_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_mult
// 64 x 64 -> 128 bit unsigned multiplier, four 32 x 32 partial products
// taken one per cycle into an accumulator.
// ----------------------------------------------------------------------------
module wis_mult (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic          done,
    output logic [127:0]  product
);
    import wis_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic         run_reg;
    logic [1:0]   step_reg;
    logic [63:0]  p_reg;
    logic [1:0]   psh_reg;
    logic         pv_reg;
    logic         plast_reg;
    logic         done_reg;
    logic [127:0] acc_reg;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [6:0]   shift;

    // Operand halves for the current step
    assign a_part = step_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_part = step_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign shift  = {psh_reg, 5'b0};

    // Step sequencing
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            step_reg  <= '0;
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pv_reg    <= run_reg;
            plast_reg <= run_reg && (step_reg == 2'd3);
            done_reg  <= pv_reg && plast_reg;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                    run_reg <= 1'b0;
            end
        end
    end

    // Partial product and accumulate
    always_ff @(posedge clk) begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        p_reg   <= a_part * b_part;
        psh_reg <= {1'b0, step_reg[0]} + {1'b0, step_reg[1]};
        if (start)
            acc_reg <= '0;
        else if (pv_reg)
            acc_reg <= acc_reg + (128'(p_reg) << shift);
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> src/wis_rng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_rng
// xorshift64 generator state: reload from seed, single-step advance.
// ----------------------------------------------------------------------------
module wis_rng (
    input  logic              clk,
    input  logic              rst_n,
    input  wis_pkg::rng_ctl_t ctl,
    input  logic [63:0]       seed,
    output logic [63:0]       state_next
);
    import wis_pkg::*;

    logic [63:0] gen_reg;
    logic [63:0] s1;
    logic [63:0] s2;

    // Three xor-shift stages
    assign s1         = gen_reg ^ (gen_reg >> 12);
    assign s2         = s1 ^ (s1 << 25);
    assign state_next = s2 ^ (s2 >> 27);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            gen_reg <= GOLDEN_SEED;
        else if (ctl.load)
            gen_reg <= (seed != 64'd0) ? seed : GOLDEN_SEED;
        else if (ctl.step)
            gen_reg <= state_next;
    end

endmodule

>>> src/wis_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_table
// Cumulative sum memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wis_table #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [wis_pkg::TOTAL_BITS-1:0] wdata,
    input  logic [AW-1:0]                  raddr,
    output logic [wis_pkg::TOTAL_BITS-1:0] rdata
);
    import wis_pkg::*;

    logic [TOTAL_BITS-1:0] mem [DEPTH];
    logic [TOTAL_BITS-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/weighted_index_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_index_sampler_core
// Weighted random index sampler: cumulative table, xorshift64* draw,
// inverse-CDF lower-bound search.
// ----------------------------------------------------------------------------
// One request is worked at a time. Clear, append and unused codes do not
// hold the input off. A draw on an empty table or zero total goes straight
// to the emit state and gives index 0 with table_empty set, holding the
// input off while in that state. Any other draw holds the input off until
// its result appears, at the same edge that frees the input: the generator
// state steps, then the scramble and the scaling product each pass through
// the shared four-step 32 x 32 multiplier, then every probe of the binary
// search passes a read state for the registered table read and a compare
// state, with one more read state to close the search and the emit state
// to load the result. A finished result sits in an output register, so new
// beats are taken while it waits on out_stall. The seed register takes
// effect at the next clear.
// ----------------------------------------------------------------------------
module weighted_index_sampler_core #(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned WEIGHT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] weight,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  index,
    output logic        table_empty
);
    import wis_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned WM = (WEIGHT_BITS < WEIGHT_PORT_BITS) ?
                                 WEIGHT_BITS : WEIGHT_PORT_BITS;
    localparam logic [WEIGHT_PORT_BITS-1:0] WEIGHT_MASK =
        WEIGHT_PORT_BITS'((33'(1) << WM) - 33'(1));

    state_t state_reg;
    state_t state_next;

    logic [63:0]           seed_reg;
    logic [CW-1:0]         count_reg;
    logic [TOTAL_BITS-1:0] total_reg;

    logic [CW-1:0]         lo_reg;
    logic [CW-1:0]         hi_reg;
    logic [CW-1:0]         mid_reg;
    logic [TOTAL_BITS-1:0] r_reg;
    logic [CW-1:0]         res_idx_reg;
    logic                  res_empty_reg;

    logic                  out_valid_reg;
    logic [7:0]            index_reg;
    logic                  empty_reg;

    logic                  in_accept;
    logic                  emit_ok;
    logic                  is_empty;
    logic                  table_full;
    logic [TOTAL_BITS:0]   sum_wide;
    logic [TOTAL_BITS-1:0] total_new;
    logic                  tbl_we;
    logic [CW-1:0]         mid;
    logic [TOTAL_BITS-1:0] r_ceil;

    rng_ctl_t              rng_ctl;
    logic [63:0]           rng_nxt;
    logic                  mult_start;
    logic [63:0]           mult_a;
    logic [63:0]           mult_b;
    logic                  mult_done;
    logic [127:0]          mult_product;
    logic [TOTAL_BITS-1:0] tbl_rdata;

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign emit_ok   = !out_valid_reg || !out_stall;

    // Table status and saturating append sum
    assign is_empty   = (count_reg == '0) || (total_reg == '0);
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign sum_wide   = {1'b0, total_reg} + (TOTAL_BITS + 1)'(weight & WEIGHT_MASK);
    assign total_new  = sum_wide[TOTAL_BITS] ? TOTAL_MAX : sum_wide[TOTAL_BITS-1:0];
    assign tbl_we     = in_accept && (req_type == REQ_APPEND) && !table_full;

    // Search midpoint and rounded-up scaled draw
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign r_ceil = mult_product[FRAC_BITS+TOTAL_BITS-1:FRAC_BITS]
                  + TOTAL_BITS'(|mult_product[FRAC_BITS-1:0]);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (req_type == REQ_DRAW))
                    state_next = is_empty ? ST_EMIT : ST_RNG;
            end
            ST_RNG:  state_next = ST_MUL1;
            ST_MUL1:
            begin
                if (mult_done)
                    state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (mult_done)
                    state_next = ST_RD;
            end
            ST_RD:   state_next = (lo_reg < hi_reg) ? ST_CMP : ST_EMIT;
            ST_CMP:  state_next = ST_RD;
            ST_EMIT:
            begin
                if (emit_ok)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        rng_ctl.load = in_accept && (req_type == REQ_CLEAR);
        rng_ctl.step = 1'b0;
        mult_start   = 1'b0;
        mult_a       = rng_nxt;
        mult_b       = SCRAMBLE_MULT;
        unique case (state_reg)
            ST_RNG:
            begin
                rng_ctl.step = 1'b1;
                mult_start   = 1'b1;
            end
            ST_MUL1:
            begin
                mult_start = mult_done;
                mult_a     = 64'(mult_product[63:64-FRAC_BITS]);
                mult_b     = 64'(total_reg);
            end
            default:
            begin
                mult_start = 1'b0;
            end
        endcase
    end

    // State, table bookkeeping, seed and result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                seed_reg <= cfg_wdata;
            if (in_accept && (req_type == REQ_CLEAR))
            begin
                count_reg <= '0;
                total_reg <= '0;
            end
            else if (tbl_we)
            begin
                count_reg <= count_reg + CW'(1);
                total_reg <= total_new;
            end
            if ((state_reg == ST_EMIT) && emit_ok)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Search datapath and result payload
    always_ff @(posedge clk) begin
        if (in_accept)
        begin
            res_idx_reg   <= '0;
            res_empty_reg <= 1'b1;
        end
        if ((state_reg == ST_MUL2) && mult_done)
        begin
            r_reg  <= r_ceil;
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        if (state_reg == ST_RD)
        begin
            mid_reg <= mid;
            if (lo_reg >= hi_reg)
            begin
                res_idx_reg   <= (lo_reg >= count_reg) ? count_reg - CW'(1) : lo_reg;
                res_empty_reg <= 1'b0;
            end
        end
        if (state_reg == ST_CMP)
        begin
            if (tbl_rdata >= r_reg)
                hi_reg <= mid_reg;
            else
                lo_reg <= mid_reg + CW'(1);
        end
        if ((state_reg == ST_EMIT) && emit_ok)
        begin
            index_reg <= 8'(res_idx_reg);
            empty_reg <= res_empty_reg;
        end
    end

    // Generator state
    wis_rng u_rng (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rng_ctl),
        .seed       (seed_reg),
        .state_next (rng_nxt)
    );

    // Shared multiplier
    wis_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mult_start),
        .a       (mult_a),
        .b       (mult_b),
        .done    (mult_done),
        .product (mult_product)
    );

    // Cumulative sum memory
    wis_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (total_new),
        .raddr (mid[AW-1:0]),
        .rdata (tbl_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign index       = index_reg;
    assign table_empty = empty_reg;

    // Fill count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Multiplier finishes only while the sequencer waits on it
    a_mult_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mult_done |-> (state_reg == ST_MUL1) || (state_reg == ST_MUL2))
        else $error("multiplier done outside a multiply state");

    // Every probe reads a stored entry
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (mid_reg < count_reg))
        else $error("search probe beyond fill count");

    // An empty result always carries index zero
    a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_empty) |-> (index == 8'd0))
        else $error("empty result with nonzero index");

    // Clear leaves an empty table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req_type == REQ_CLEAR)) |=> (count_reg == '0) && (total_reg == '0))
        else $error("clear did not empty the table");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for weighted_index_sampler_core.
// Sends clear, append, draw and unused beats with random gaps and random result
// stalls. A local copy of the cumulative table, the running total and the
// xorshift64* generator predicts every draw. Each result beat is checked in
// order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import wis_pkg::*;

    localparam int unsigned DEPTH         = 256;
    localparam int unsigned RANDOM_ITEMS  = 1300;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;

    typedef struct packed {
        logic [7:0] idx;
        logic       empty;
    } draw_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_CLEAR;
    logic [31:0] weight = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  index;
    logic        table_empty;

    // Shadow of the sampler state
    logic [TOTAL_BITS-1:0] cum_sums [DEPTH];
    int unsigned           n_entries;
    logic [TOTAL_BITS-1:0] total;
    logic [63:0]           gen_state;
    logic [63:0]           seed_shadow;

    draw_result_t pending_draws [$];
    int unsigned  fail_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  items_sent = 0;
    bit           no_gaps = 1'b0;

    // Result-side stall shaping
    int unsigned  stall_left = 0;
    int unsigned  stall_phase = 0;
    bit           calm = 1'b0;

    weighted_index_sampler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .index       (index),
        .table_empty (table_empty)
    );

    always #1 clk = ~clk;

    // xorshift64* step, returns the top 53 bits of the scrambled word
    function automatic logic [52:0] advance_generator();
        logic [63:0] s;
        logic [63:0] scrambled;
        s = gen_state;
        s = s ^ (s >> 12);
        s = s ^ (s << 25);
        s = s ^ (s >> 27);
        gen_state = s;
        scrambled = s * SCRAMBLE_MULT;
        return scrambled[63:11];
    endfunction

    // Inverse-CDF lookup: first entry whose sum reaches ceil(f * total / 2^53)
    function automatic draw_result_t predict_draw();
        draw_result_t res;
        logic [52:0]  frac;
        logic [127:0] scaled;
        logic [63:0]  target;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        res.idx   = 8'd0;
        res.empty = 1'b1;
        if (n_entries == 0 || total == '0)
            return res;
        frac   = advance_generator();
        scaled = 128'(frac) * 128'(total);
        target = scaled[116:53];
        if (scaled[52:0] != '0)
            target = target + 64'd1;
        lo = 0;
        hi = n_entries;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (64'(cum_sums[mid]) >= target)
                hi = mid;
            else
                lo = mid + 1;
        end
        if (lo >= n_entries)
            lo = n_entries - 1;
        res.idx   = lo[7:0];
        res.empty = 1'b0;
        return res;
    endfunction

    // Apply one accepted request beat to the shadow state
    function automatic void predict_request(input logic [1:0] rq, input logic [31:0] w);
        logic [TOTAL_BITS:0] sum;
        logic [TOTAL_BITS:0] wide_w;
        case (rq)
            REQ_CLEAR:
            begin
                n_entries = 0;
                total     = '0;
                gen_state = (seed_shadow != '0) ? seed_shadow : GOLDEN_SEED;
            end
            REQ_APPEND:
            begin
                // full table drops the append
                if (n_entries < DEPTH)
                begin
                    wide_w = (TOTAL_BITS + 1)'(w);
                    sum    = {1'b0, total} + wide_w;
                    total  = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
                    cum_sums[n_entries] = total;
                    n_entries++;
                end
            end
            REQ_DRAW:
                pending_draws = {pending_draws, predict_draw()};
            default:
                ;
        endcase
    endfunction

    // Predict on accepted requests, check result beats, watchdog
    always @(posedge clk)
    begin
        draw_result_t want;
        if (!rst_n)
        begin
            n_entries   = 0;
            total       = '0;
            gen_state   = GOLDEN_SEED;
            seed_shadow = '0;
            idle_cycles = 0;
        end
        else
        begin
            if (cfg_we)
                seed_shadow = cfg_wdata;
            if (in_valid && !in_stall)
                predict_request(req_type, weight);
            if (out_valid && !out_stall)
            begin
                if (pending_draws.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result beat with no draw pending: index %0d empty %0b",
                                 $realtime, index, table_empty);
                end
                else
                begin
                    want = pending_draws.pop_front();
                    if (index !== want.idx || table_empty !== want.empty)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: expected index %0d empty %0b, got %0d %0b",
                                     $realtime, want.idx, want.empty, index, table_empty);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog, no beat for %0d cycles", $realtime, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result stall: calm stretches, otherwise mostly short stalls, a few long
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            calm        = ($urandom_range(0, 3) == 0);
            stall_phase = 300;
        end
        stall_phase--;
        if (stall_left > 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 99) < 30)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
        out_stall <= (stall_left > 0);
    end

    // Send one request beat, then an optional gap
    task automatic send_beat(input logic [1:0] rq, input logic [31:0] w);
        int unsigned gap;
        int unsigned roll;
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rq;
        weight   <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (rq != REQ_UNUSED)
            items_sent++;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 20);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Drop valid, let all draws return and the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return '1;
            2, 3:    return $urandom_range(1, 15);
            4, 5:    return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Draws on an empty table, unused code
    task automatic test_empty_table();
        send_beat(REQ_DRAW, '1);
        send_beat(REQ_UNUSED, '1);
        send_beat(REQ_DRAW, 32'd0);
        send_beat(REQ_CLEAR, 32'd0);
        send_beat(REQ_DRAW, 32'h5a5a_5a5a);
    endtask

    // Entries present but zero total, then leading zero-weight entries
    task automatic test_zero_total();
        send_beat(REQ_CLEAR, '1);
        send_beat(REQ_APPEND, 32'd0);
        send_beat(REQ_APPEND, 32'd0);
        send_beat(REQ_DRAW, 32'd0);
        send_beat(REQ_DRAW, '1);
        send_beat(REQ_APPEND, 32'd3);
        send_beat(REQ_DRAW, 32'd0);
        send_beat(REQ_DRAW, 32'd0);
    endtask

    // Seed and weight extremes
    task automatic test_weight_extremes();
        write_seed('1);
        send_beat(REQ_CLEAR, 32'd0);
        send_beat(REQ_APPEND, 32'd1);
        send_beat(REQ_DRAW, 32'd0);
        send_beat(REQ_APPEND, '1);
        send_beat(REQ_DRAW, 32'd0);
        send_beat(REQ_DRAW, 32'd0);
        send_beat(REQ_APPEND, 32'h8000_0000);
        send_beat(REQ_APPEND, 32'd0);
        send_beat(REQ_DRAW, 32'd0);
        send_beat(REQ_DRAW, 32'd0);
        write_seed(64'd1);
        send_beat(REQ_CLEAR, 32'd0);
        send_beat(REQ_APPEND, 32'd7);
        send_beat(REQ_DRAW, 32'd0);
    endtask

    // Fill the table past its depth; extra appends are dropped
    task automatic test_table_full();
        write_seed({$urandom, $urandom});
        send_beat(REQ_CLEAR, 32'd0);
        repeat (DEPTH + 4)
            send_beat(REQ_APPEND, rand_weight());
        repeat (12)
            send_beat(REQ_DRAW, $urandom);
        send_beat(REQ_CLEAR, 32'd0);
        send_beat(REQ_DRAW, 32'd0);
    endtask

    // Clear, build a table, draw from it; some noise mixed in
    task automatic test_random_traffic();
        int unsigned roll;
        int unsigned appends_left;
        int unsigned draws_left;
        logic [63:0] seed_pick;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       seed_pick = '0;
                    1:       seed_pick = '1;
                    2:       seed_pick = 64'd1;
                    default: seed_pick = {$urandom, $urandom};
                endcase
                write_seed(seed_pick);
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            send_beat(REQ_CLEAR, $urandom);
            roll = $urandom_range(0, 99);
            if (roll < 10)
                appends_left = 0;
            else if (roll < 75)
                appends_left = $urandom_range(1, 12);
            else if (roll < 95)
                appends_left = $urandom_range(13, 64);
            else
                appends_left = $urandom_range(65, DEPTH + 4);
            draws_left = $urandom_range(1, 16);
            while (appends_left + draws_left > 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    send_beat(REQ_UNUSED, $urandom);
                else if (appends_left > 0 && (draws_left == 0 || roll < 75))
                begin
                    send_beat(REQ_APPEND, rand_weight());
                    appends_left--;
                end
                else
                begin
                    send_beat(REQ_DRAW, $urandom);
                    draws_left--;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_zero_total();
        test_weight_extremes();
        test_table_full();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0 && pending_draws.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
